@@ hw/rtl/hcf_pkg.sv @@
package hcf_pkg;

	localparam int MAX_WIDTH = 64;
	localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
	localparam int PREC_W    = 6;
	localparam int VALUE_W   = 64;
	localparam int NIB_W     = $clog2(VALUE_W / 4);
	localparam int NDIG_W    = $clog2(VALUE_W / 4 + 1);
	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 7;
	localparam int Q_DEPTH   = 2;
	localparam int Q_AW      = $clog2(Q_DEPTH);
	localparam int Q_CW      = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	typedef enum logic [CFG_AW-1:0] {
		REG_FIELD_WIDTH,
		REG_MIN_DIGITS,
		REG_PRECISION_GIVEN,
		REG_ZERO_FILL,
		REG_ALT_FORM,
		REG_LEFT_JUSTIFY,
		REG_UPPER_CASE,
		REG_LENGTH_MODE
	} hcf_reg_t;

	typedef enum logic [1:0] {
		LEN_32,
		LEN_8,
		LEN_16,
		LEN_64
	} hcf_len_t;

	typedef struct packed {
		logic [CNT_W-1:0]  field_width;
		logic [PREC_W-1:0] min_digits;
		logic              precision_given;
		logic              zero_fill;
		logic              alt_form;
		logic              left_justify;
		logic              upper_case;
		hcf_len_t          length_mode;
	} hcf_cfg_t;

	// Value, case and segment boundaries of one formatted text; boundaries as character positions
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               upper;
		logic [CNT_W-1:0]   prefix_start;
		logic [CNT_W-1:0]   fill_start;
		logic [CNT_W-1:0]   digit_start;
		logic [CNT_W-1:0]   digit_last;
		logic [CNT_W-1:0]   char_last;
	} hcf_desc_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [7:0] c;
		if (nib < 4'd10)
			c = CH_ZERO + {4'd0, nib};
		else if (upper)
			c = 8'h41 + {4'd0, nib - 4'd10};
		else
			c = 8'h61 + {4'd0, nib - 4'd10};
		return c;
	endfunction

endpackage

@@ hw/rtl/hcf_if.sv @@
interface hcf_in_if;
	import hcf_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface hcf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;
	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface hcf_cfg_if;
	import hcf_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] addr;
	logic [CFG_DW-1:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ hw/rtl/hex_conversion_formatter_top.sv @@
// A value passes the front register, a queue entry and the emitter's descriptor and output
// registers before reaching text. Throughput: one character per cycle while text is ready;
// a value's text is max(field width capped at 64, its text length) characters, 1 to 64.
// Values are accepted back to back while earlier text drains, through a 2-entry queue.
// Reset (arst_n low, asynchronous) clears the format registers to 0 and empties every stage;
// data registers are not reset.
module hex_conversion_formatter_top
	import hcf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hcf_cfg_if.sink   cfg,
	hcf_in_if.sink    arg,
	hcf_out_if.source text
);

	hcf_cfg_t  cfg_q;
	logic      push_valid;
	hcf_desc_t push_desc;
	logic      push_ready;
	logic      pop_valid;
	hcf_desc_t pop_desc;
	logic      pop_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (hcf_reg_t'(cfg.addr))
				REG_FIELD_WIDTH:     cfg_q.field_width     <= cfg.data[CNT_W-1:0];
				REG_MIN_DIGITS:      cfg_q.min_digits      <= cfg.data[PREC_W-1:0];
				REG_PRECISION_GIVEN: cfg_q.precision_given <= cfg.data[0];
				REG_ZERO_FILL:       cfg_q.zero_fill       <= cfg.data[0];
				REG_ALT_FORM:        cfg_q.alt_form        <= cfg.data[0];
				REG_LEFT_JUSTIFY:    cfg_q.left_justify    <= cfg.data[0];
				REG_UPPER_CASE:      cfg_q.upper_case      <= cfg.data[0];
				REG_LENGTH_MODE:     cfg_q.length_mode     <= hcf_len_t'(cfg.data[1:0]);
				default: ;
			endcase
		end
	end

	hcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.arg        (arg),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_desc  (push_desc),
		.push_ready (push_ready)
	);

	hcf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_desc  (push_desc),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_desc   (pop_desc),
		.pop_ready  (pop_ready)
	);

	hcf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_desc  (pop_desc),
		.pop_ready (pop_ready),
		.text      (text)
	);

endmodule

@@ hw/rtl/hcf_front.sv @@
module hcf_front
	import hcf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	hcf_in_if.sink       arg,
	input  hcf_cfg_t     cfg,
	output logic         push_valid,
	output hcf_desc_t    push_desc,
	input  logic         push_ready
);

	logic               vld_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [NDIG_W-1:0]  ndig_s1;

	logic [VALUE_W-1:0] cut;
	logic [NDIG_W-1:0]  ndig;

	always_comb begin
		case (cfg.length_mode)
			LEN_8:   cut = {56'd0, arg.value[7:0]};
			LEN_16:  cut = {48'd0, arg.value[15:0]};
			LEN_64:  cut = arg.value;
			default: cut = {32'd0, arg.value[31:0]};
		endcase
		// zero still prints one digit
		ndig = NDIG_W'(1);
		for (int i = 1; i < VALUE_W / 4; i++) begin
			if (cut[i*4 +: 4] != 4'd0)
				ndig = NDIG_W'(i + 1);
		end
	end

	assign arg.ready = !vld_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (arg.ready) begin
			vld_s1 <= arg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (arg.valid && arg.ready) begin
			value_s1 <= cut;
			ndig_s1  <= ndig;
		end
	end

	logic [CNT_W-1:0]  width;
	logic [PREC_W-1:0] prec;
	logic [PREC_W-1:0] zeros;
	logic [CNT_W-1:0]  prefix;
	logic [CNT_W-1:0]  body;
	logic [CNT_W-1:0]  pad;
	logic [CNT_W-1:0]  lead;
	logic [CNT_W-1:0]  zpad;

	always_comb begin
		width  = (cfg.field_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : cfg.field_width;
		prec   = (cfg.min_digits > PREC_W'(MAX_WIDTH - 2)) ?
			PREC_W'(MAX_WIDTH - 2) : cfg.min_digits;
		zeros  = (cfg.precision_given && (prec > PREC_W'(ndig_s1))) ?
			prec - PREC_W'(ndig_s1) : PREC_W'(0);
		prefix = (cfg.alt_form && (value_s1 != '0)) ? CNT_W'(2) : CNT_W'(0);
		body   = prefix + CNT_W'(zeros) + CNT_W'(ndig_s1);
		pad    = (width > body) ? width - body : CNT_W'(0);
		lead   = (!cfg.left_justify && !cfg.zero_fill) ? pad : CNT_W'(0);
		zpad   = (!cfg.left_justify && cfg.zero_fill) ? pad : CNT_W'(0);

		push_desc.value        = value_s1;
		push_desc.upper        = cfg.upper_case;
		push_desc.prefix_start = lead;
		push_desc.fill_start   = lead + prefix;
		push_desc.digit_start  = lead + prefix + zpad + CNT_W'(zeros);
		push_desc.digit_last   = lead + body + zpad - CNT_W'(1);
		push_desc.char_last    = body + pad - CNT_W'(1);
	end

	assign push_valid = vld_s1;

endmodule

@@ hw/rtl/hcf_queue.sv @@
module hcf_queue
	import hcf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  hcf_desc_t push_desc,
	output logic      push_ready,
	output logic      pop_valid,
	output hcf_desc_t pop_desc,
	input  logic      pop_ready
);

	hcf_desc_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_CW-1:0]   cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != Q_CW'(Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_desc   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + Q_CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - Q_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_desc;
	end

endmodule

@@ hw/rtl/hcf_emit.sv @@
module hcf_emit
	import hcf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	input  hcf_desc_t pop_desc,
	output logic      pop_ready,
	hcf_out_if.source text
);

	logic             busy_q;
	hcf_desc_t        desc_q;
	logic [CNT_W-1:0] pos_q;
	logic             valid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic             adv;
	logic             at_last;
	logic             take;
	logic [NIB_W-1:0] dig_idx;
	logic [3:0]       nib;
	logic [7:0]       ch;

	assign adv       = busy_q && (!valid_q || text.ready);
	assign at_last   = (pos_q == desc_q.char_last);
	assign pop_ready = !busy_q || (adv && at_last);
	assign take      = pop_valid && pop_ready;

	always_comb begin
		dig_idx = NIB_W'(desc_q.digit_last - pos_q);
		nib     = desc_q.value[{dig_idx, 2'b00} +: 4];
		if (pos_q < desc_q.prefix_start)
			ch = CH_SPACE;
		else if (pos_q < desc_q.fill_start)
			ch = (pos_q == desc_q.prefix_start) ? CH_ZERO :
				(desc_q.upper ? CH_X_UP : CH_X_LO);
		else if (pos_q < desc_q.digit_start)
			ch = CH_ZERO;
		else if (pos_q <= desc_q.digit_last)
			ch = hex_char(nib, desc_q.upper);
		else
			ch = CH_SPACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (adv && at_last) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				pos_q <= pos_q + CNT_W'(1);
			end
			if (adv)
				valid_q <= 1'b1;
			else if (text.ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			desc_q <= pop_desc;
		if (adv) begin
			char_q <= ch;
			last_q <= at_last;
		end
	end

	assign text.valid     = valid_q;
	assign text.char_code = char_q;
	assign text.last_char = last_q;

endmodule

@@ hw/rtl/hcf_checker.sv @@
module hcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] char_code,
	input logic       last_char
);

	logic       out_acc;
	logic       in_acc;
	logic [3:0] pending_q;
	logic [7:0] prev_char_q;
	logic       prev_last_q;

	assign out_acc = out_valid && out_ready;
	assign in_acc  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			prev_char_q <= 8'h00;
			prev_last_q <= 1'b1;
		end else begin
			if (in_acc && !(out_acc && last_char))
				pending_q <= pending_q + 4'd1;
			else if (!in_acc && out_acc && last_char)
				pending_q <= pending_q - 4'd1;
			if (out_acc) begin
				prev_char_q <= char_code;
				prev_last_q <= last_char;
			end
		end
	end

	// hold a stalled character
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char))
		else $error("stalled character changed");

	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == 8'h20) || (char_code == 8'h78) || (char_code == 8'h58)
			|| ((char_code >= 8'h30) && (char_code <= 8'h39))
			|| ((char_code >= 8'h41) && (char_code <= 8'h46))
			|| ((char_code >= 8'h61) && (char_code <= 8'h66)))
		else $error("character outside hex text set");

	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && ((char_code == 8'h78) || (char_code == 8'h58))
			|-> (prev_char_q == 8'h30) && !prev_last_q && !last_char)
		else $error("prefix letter not preceded by 0 within one text");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("character with no value outstanding");

endmodule

bind hex_conversion_formatter_top hcf_checker u_hcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (arg.valid),
	.in_ready  (arg.ready),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.char_code (text.char_code),
	.last_char (text.last_char)
);
